>>> src/tvi_pkg.sv
// Shared types, constants and helpers for the trilinear velocity interpolator.
// No dependencies; imported by tvi_alu and the top level.
package tvi_pkg;

    localparam int COMP_W     = 16;  // Q1.15 velocity component
    localparam int NUM_COMP   = 3;
    localparam int PROD_W     = 50;  // signed 17 x unsigned 32 product
    localparam int CELL_W     = 5;
    localparam int POS_W      = 21;
    localparam int SIZE_REG_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SCALE_W    = 32;
    localparam int OUT_W      = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd3;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
        logic [CELL_W-1:0]        cell_z;
        logic signed [COMP_W-1:0] vel_x;
        logic signed [COMP_W-1:0] vel_y;
        logic signed [COMP_W-1:0] vel_z;
        logic [POS_W-1:0]         pos_x;
        logic [POS_W-1:0]         pos_y;
        logic [POS_W-1:0]         pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_vel_x;
        logic signed [OUT_W-1:0] out_vel_y;
        logic signed [OUT_W-1:0] out_vel_z;
        logic                    outside;
    } t_out_item;

    // Three components, element 0 is x
    typedef logic [NUM_COMP-1:0][COMP_W-1:0] t_vec;
    typedef logic [NUM_COMP-1:0][PROD_W-1:0] t_prod_vec;

    // Control of the shared blend / scale unit
    typedef struct packed {
        logic               scale_sel;  // 1: plain product for scaling, 0: blend
        logic [SCALE_W-1:0] mult;       // fraction (zero-extended) or scale
    } t_alu_ctl;

    // Q1.15 x Q16.16 product to Q16.16: round half up, saturate to 32 bits
    function automatic logic [OUT_W-1:0] sat_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        logic [PROD_W-OUT_W:0]    hi;
        r  = (p + $signed(PROD_W'(16384))) >>> 15;
        hi = r[PROD_W-1:OUT_W-1];
        if (hi == '0 || hi == '1) begin
            return r[OUT_W-1:0];
        end else if (r[PROD_W-1]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

endpackage

>>> src/tvi_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tvi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access per cycle: write or read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tvi_alu.sv
// Shared three-lane blend / scale unit: one multiplier per component lane.
// Depends on tvi_pkg.
module tvi_alu #(
    parameter int FRAC_BITS = 16
) (
    input  tvi_pkg::t_alu_ctl  i_ctl,
    input  tvi_pkg::t_vec      i_a,
    input  tvi_pkg::t_vec      i_b,
    output tvi_pkg::t_vec      o_blend,
    output tvi_pkg::t_prod_vec o_prod
);
    import tvi_pkg::*;

    // rounding offset: half of one fraction step
    localparam logic signed [PROD_W-1:0] HALF = $signed(PROD_W'(1) << (FRAC_BITS - 1));

    // blend = a + round((b - a) * f / 2^F), ties upward
    for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
        logic signed [COMP_W:0]   diff;
        logic signed [COMP_W:0]   opa;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] rnd;

        assign diff = $signed({i_b[g][COMP_W-1], i_b[g]}) - $signed({i_a[g][COMP_W-1], i_a[g]});
        assign opa  = i_ctl.scale_sel ? $signed({i_a[g][COMP_W-1], i_a[g]}) : diff;
        assign prod = opa * $signed({1'b0, i_ctl.mult});
        assign rnd  = (prod + HALF) >>> FRAC_BITS;

        assign o_blend[g] = i_a[g] + rnd[COMP_W-1:0];
        assign o_prod[g]  = prod;
    end

endmodule

>>> src/trilinear_velocity_interpolator.sv
// Top level of the trilinear velocity interpolator: lattice store, sequencer, output stage.
// Depends on tvi_pkg, tvi_ram and tvi_alu.
//
// Usage:
//   Input channel (i_valid / o_ready, i_item) carries write beats (func = write) that
//   load one lattice velocity, and query beats (func = query) with a fixed-point position.
//   Output channel (o_valid / i_ready, o_item) carries one beat per query, none per write.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), taken at once;
//   write it only while the block is idle.
// Timing:
//   Write beats leave o_ready high, so writes stream at one per cycle.
//   A query occupies the block (o_ready low) while it runs: the eight corner vectors come one per cycle
//   from the single lattice RAM port, seven blends run through the shared three-lane unit
//   as the corners arrive, then one scale product and one round/saturate step.
//   The result is loaded into the output register by the last step, ST_OUT.
// Reset and stall:
//   Reset returns to idle, drops o_valid and restores sizes 32 (capped at GRID_DIM) and
//   scale 1.0. The lattice store is not cleared; only written points may be queried.
//   While a result waits in the output register the block still takes new beats; a
//   finished query holds in its last step until the output register is free.
module trilinear_velocity_interpolator #(
    parameter int GRID_DIM  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  tvi_pkg::t_in_item                  i_item,
    output logic                               o_valid,
    input  logic                               i_ready,
    output tvi_pkg::t_out_item                 o_item,
    input  logic                               i_cfg_we,
    input  logic [tvi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tvi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tvi_pkg::*;

    localparam int DEPTH    = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(GRID_DIM);
    localparam int SW       = $clog2(GRID_DIM + 1);
    localparam int SIZE_RST = (GRID_DIM < 32) ? GRID_DIM : 32;
    localparam int STEP_W   = 4;

    // sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    // sequencer steps (reads issue at steps 0..7, data in the next step)
    localparam logic [STEP_W-1:0] ST_X00       = 4'd2;
    localparam logic [STEP_W-1:0] ST_X10       = 4'd4;
    localparam logic [STEP_W-1:0] ST_YLO       = 4'd5;
    localparam logic [STEP_W-1:0] ST_X01       = 4'd6;
    localparam logic [STEP_W-1:0] ST_X11       = 4'd8;
    localparam logic [STEP_W-1:0] ST_LAST_DATA = 4'd8;
    localparam logic [STEP_W-1:0] ST_YHI       = 4'd9;
    localparam logic [STEP_W-1:0] ST_Z         = 4'd10;
    localparam logic [STEP_W-1:0] ST_SCALE     = 4'd11;
    localparam logic [STEP_W-1:0] ST_OUT       = 4'd12;

    typedef struct packed {
        logic [CW-1:0]        lo;
        logic [CW-1:0]        hi;
        logic [FRAC_BITS-1:0] frac;
        logic                 clip;
    } t_axis;

    // size register write: below 2 acts as 2, above GRID_DIM as GRID_DIM
    function automatic logic [SW-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v);
        if (v < SIZE_REG_W'(2)) begin
            return SW'(2);
        end else if (32'(v) > 32'(GRID_DIM)) begin
            return SW'(GRID_DIM);
        end else begin
            return SW'(v);
        end
    endfunction

    // corner pair and fraction along one axis, clamped to the last lattice point
    function automatic t_axis axis_of(input logic [POS_W-1:0] pos, input logic [SW-1:0] size);
        t_axis      ax;
        logic [47:0] pe;
        logic [47:0] ip;
        logic [47:0] top;
        pe      = 48'(pos);
        ip      = pe >> FRAC_BITS;
        top     = 48'(size) - 48'd1;
        ax.frac = pe[FRAC_BITS-1:0];
        ax.clip = (ip + 48'd1) > top;
        ax.lo   = (ip > top) ? top[CW-1:0] : ip[CW-1:0];
        ax.hi   = ((ip + 48'd1) > top) ? top[CW-1:0] : ip[CW-1:0] + CW'(1);
        return ax;
    endfunction

    // configuration registers
    logic [SW-1:0]      r_size_x, r_size_y, r_size_z;
    logic [AW-1:0]      r_szy;
    logic [SCALE_W-1:0] r_scale;
    logic [SW-1:0]      n_cfg_size, m_y, m_z;
    logic [AW-1:0]      n_szy;

    // sequencer and datapath
    logic               r_state;
    logic [STEP_W-1:0]  r_step;
    t_axis              r_ax_x, r_ax_y, r_ax_z;
    t_axis              n_ax_x, n_ax_y, n_ax_z;
    logic               r_outside;
    t_vec               r_xa, r_ya, r_yb, r_za, r_zb, r_v;
    t_prod_vec          r_prod;
    t_out_item          r_out;
    logic               r_out_valid;

    logic               accept, out_load, in_range;
    logic [CW-1:0]      cx, cy, cz;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    t_vec               ram_wdata, ram_rdata;
    t_alu_ctl           alu_ctl;
    t_vec               alu_a, alu_b, alu_blend;
    t_prod_vec          alu_prod;

    // ---------------------------------------------------------------- config
    assign n_cfg_size = clamp_size(i_cfg_data[SIZE_REG_W-1:0]);
    assign m_y        = (i_cfg_idx == REG_SIZE_Y) ? n_cfg_size : r_size_y;
    assign m_z        = (i_cfg_idx == REG_SIZE_Z) ? n_cfg_size : r_size_z;
    assign n_szy      = AW'(m_y) * AW'(m_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SW'(SIZE_RST);
            r_size_y <= SW'(SIZE_RST);
            r_size_z <= SW'(SIZE_RST);
            r_szy    <= AW'(SIZE_RST * SIZE_RST);
            r_scale  <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            // y*z-plane stride kept in step with the size registers
            r_szy <= n_szy;
            case (i_cfg_idx)
                REG_SIZE_X: r_size_x <= n_cfg_size;
                REG_SIZE_Y: r_size_y <= n_cfg_size;
                REG_SIZE_Z: r_size_z <= n_cfg_size;
                REG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input side
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign in_range = ({27'b0, i_item.cell_x} < 32'(r_size_x))
                   && ({27'b0, i_item.cell_y} < 32'(r_size_y))
                   && ({27'b0, i_item.cell_z} < 32'(r_size_z));

    // lattice address: write cell when idle, else corner picked by the step bits
    always_comb begin
        if (r_state == S_IDLE) begin
            cx = CW'(i_item.cell_x);
            cy = CW'(i_item.cell_y);
            cz = CW'(i_item.cell_z);
        end else begin
            cx = r_step[0] ? r_ax_x.hi : r_ax_x.lo;
            cy = r_step[1] ? r_ax_y.hi : r_ax_y.lo;
            cz = r_step[2] ? r_ax_z.hi : r_ax_z.lo;
        end
    end

    assign ram_addr  = AW'(cz) + AW'(cy) * AW'(r_size_z) + AW'(cx) * r_szy;
    assign ram_we    = accept && (i_item.func == FUNC_WRITE) && in_range;
    assign ram_wdata = {i_item.vel_z, i_item.vel_y, i_item.vel_x};

    tvi_ram #(
        .WIDTH (NUM_COMP * COMP_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- shared unit
    always_comb begin
        alu_ctl.scale_sel = 1'b0;
        alu_ctl.mult      = SCALE_W'(r_ax_x.frac);
        alu_a             = r_xa;
        alu_b             = ram_rdata;
        case (r_step)
            ST_YLO, ST_YHI: begin
                alu_ctl.mult = SCALE_W'(r_ax_y.frac);
                alu_a        = r_ya;
                alu_b        = r_yb;
            end
            ST_Z: begin
                alu_ctl.mult = SCALE_W'(r_ax_z.frac);
                alu_a        = r_za;
                alu_b        = r_zb;
            end
            ST_SCALE: begin
                alu_ctl.scale_sel = 1'b1;
                alu_ctl.mult      = r_scale;
                alu_a             = r_v;
                alu_b             = r_v;
            end
            default: ;
        endcase
    end

    tvi_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_blend (alu_blend),
        .o_prod  (alu_prod)
    );

    // ---------------------------------------------------------------- sequencer
    assign out_load = (r_state == S_RUN) && (r_step == ST_OUT) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: filled by the last step, emptied when its beat is taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_item.func == FUNC_QUERY) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                    end
                end
                S_RUN: begin
                    if (r_step == ST_OUT) begin
                        // wait here until the output register is free
                        if (out_load) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // query position split into corners and fractions
    assign n_ax_x = axis_of(i_item.pos_x, r_size_x);
    assign n_ax_y = axis_of(i_item.pos_y, r_size_y);
    assign n_ax_z = axis_of(i_item.pos_z, r_size_z);

    always_ff @(posedge i_clk) begin
        if (accept && i_item.func == FUNC_QUERY) begin
            r_ax_x    <= n_ax_x;
            r_ax_y    <= n_ax_y;
            r_ax_z    <= n_ax_z;
            r_outside <= n_ax_x.clip | n_ax_y.clip | n_ax_z.clip;
        end
    end

    // blend tree: x pairs as corners arrive, then y, then z, then scale
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            // low-x corner of each pair parks here
            if (r_step[0] && r_step < ST_LAST_DATA) begin
                r_xa <= ram_rdata;
            end
            case (r_step)
                ST_X00, ST_X01: r_ya   <= alu_blend;
                ST_X10, ST_X11: r_yb   <= alu_blend;
                ST_YLO:         r_za   <= alu_blend;
                ST_YHI:         r_zb   <= alu_blend;
                ST_Z:           r_v    <= alu_blend;
                ST_SCALE:       r_prod <= alu_prod;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- output stage
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_vel_x <= sat_q16(r_prod[0]);
            r_out.out_vel_y <= sat_q16(r_prod[1]);
            r_out.out_vel_z <= sat_q16(r_prod[2]);
            r_out.outside   <= r_outside;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
